### src/hsmc_pkg.sv
// Shared types and constants for the hard-sphere compression engine.
// Used by every module in src; depends on nothing else.
`timescale 1ns / 1ps
package hsmc_pkg;

   localparam int AtomBits  = 8;
   localparam int CoordBits = 16;
   localparam int LenBits   = 24;
   localparam int TryBits   = 11;
   localparam int MaxTries  = 1024;
   localparam int MaxAtoms  = 256;

   localparam logic [LenBits-1:0] ResetLength = 24'd81920;
   localparam logic [16:0] GrowQ16  = 17'd68813;
   localparam logic [15:0] DecayQ16 = 16'd62259;
   localparam logic [15:0] HalfQ16  = 16'd32768;
   localparam logic [16:0] OneQ16   = 17'h10000;

   typedef enum logic [1:0] {
      OP_LOAD     = 2'd0,
      OP_EXPAND   = 2'd1,
      OP_MOVE     = 2'd2,
      OP_COMPRESS = 2'd3
   } opcode_type;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_REJECT = 2'd1;
   localparam logic [1:0] ST_GIVEUP = 2'd2;

   localparam logic [1:0] REG_ATOM_COUNT = 2'd0;
   localparam logic [1:0] REG_START_LEN  = 2'd1;
   localparam logic [1:0] REG_STEP       = 2'd2;
   localparam logic [1:0] REG_SHRINK     = 2'd3;

   typedef struct packed {
      logic [LenBits-1:0]   rad;
      logic [CoordBits-1:0] z;
      logic [CoordBits-1:0] y;
      logic [CoordBits-1:0] x;
   } atom_type;

   typedef struct packed {
      logic valid;
      logic overlap;
      logic busy;
   } pair_stat_type;

endpackage

### src/hsmc_mem.sv
// Atom store: one write port and one registered read port.
// Depends on hsmc_pkg for the atom word layout.
`timescale 1ns / 1ps
module hsmc_mem
   import hsmc_pkg::*;
(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AtomBits-1:0] wr_addr,
   input  atom_type            wr_data,
   input  logic [AtomBits-1:0] rd_addr,
   output atom_type            rd_data
);

   atom_type mem_ff [MaxAtoms];
   atom_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/hsmc_pair.sv
// Pipelined pair overlap tester: one atom pair per cycle, four register stages.
// Depends on hsmc_pkg for the atom word and the status struct.
`timescale 1ns / 1ps
module hsmc_pair
   import hsmc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  atom_type      atom_a,
   input  atom_type      atom_b,
   input  logic [47:0]   len_sq,
   output pair_stat_type stat
);

   function automatic logic [15:0] wrap_dist(input logic [15:0] a, input logic [15:0] b);
      logic [15:0] d;
      logic [16:0] w;
      begin
         d = (a >= b) ? a - b : b - a;
         w = 17'h10000 - {1'b0, d};
         wrap_dist = d[15] ? w[15:0] : d;
      end
   endfunction

   logic        s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic [15:0] dx_ff, dy_ff, dz_ff;
   logic [24:0] rsum_ff;
   logic [31:0] sqx_ff, sqy_ff, sqz_ff;
   logic [49:0] rsq2_ff, rsq3_ff, rsq4_ff;
   logic [31:0] d2_ff;
   logic [55:0] plo_ff, phi_ff;
   logic [81:0] lhs, rhs;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
      dx_ff   <= wrap_dist(atom_a.x, atom_b.x);
      dy_ff   <= wrap_dist(atom_a.y, atom_b.y);
      dz_ff   <= wrap_dist(atom_a.z, atom_b.z);
      rsum_ff <= {1'b0, atom_a.rad} + {1'b0, atom_b.rad};
      sqx_ff  <= dx_ff * dx_ff;
      sqy_ff  <= dy_ff * dy_ff;
      sqz_ff  <= dz_ff * dz_ff;
      rsq2_ff <= rsum_ff * rsum_ff;
      d2_ff   <= sqx_ff + sqy_ff + sqz_ff;
      rsq3_ff <= rsq2_ff;
      plo_ff  <= d2_ff * len_sq[23:0];
      phi_ff  <= d2_ff * len_sq[47:24];
      rsq4_ff <= rsq3_ff;
   end

   // Distance term is d2 * L^2; the radius term is scaled by 2^32 to match.
   assign lhs = {26'b0, plo_ff} + {2'b0, phi_ff, 24'b0};
   assign rhs = {rsq4_ff, 32'b0};

   assign stat.valid   = s4_valid_ff;
   assign stat.overlap = lhs < rhs;
   assign stat.busy    = s1_valid_ff | s2_valid_ff | s3_valid_ff | s4_valid_ff;

endmodule

### src/hard_sphere_mc_compress.sv
// Hard-sphere cell engine: atom store, shared length multiplier and pair tester.
// A load is written when taken; a move reads the atom, writes it displaced, runs an overlap
// check and restores the atom when it is undone. A check over n atoms tests one pair per
// cycle plus a read of atom i per row, none under two atoms; expand and compress retry it.
// One word is handled at a time. Synchronous reset clears control state and
// configuration; the atom store is not cleared.
`timescale 1ns / 1ps
module hard_sphere_mc_compress
   import hsmc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_opcode,
   input  logic [AtomBits-1:0]  req_atom_index,
   input  logic [CoordBits-1:0] req_pos_x,
   input  logic [CoordBits-1:0] req_pos_y,
   input  logic [CoordBits-1:0] req_pos_z,
   input  logic [LenBits-1:0]   req_radius,
   input  logic [15:0]          req_draw_x,
   input  logic [15:0]          req_draw_y,
   input  logic [15:0]          req_draw_z,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [LenBits-1:0]   rsp_box_size,
   output logic [TryBits-1:0]   rsp_tries_used,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [3:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   typedef enum logic [16:0] {
      S_IDLE     = 17'h00001,
      S_MV_DISP  = 17'h00002,
      S_MV_WR    = 17'h00004,
      S_GROW     = 17'h00008,
      S_GROW_WB  = 17'h00010,
      S_CAND     = 17'h00020,
      S_CAND_WB  = 17'h00040,
      S_DECAY    = 17'h00080,
      S_DECAY_WB = 17'h00100,
      S_SQ       = 17'h00200,
      S_CHK_I    = 17'h00400,
      S_CHK_A    = 17'h00800,
      S_CHK_J    = 17'h01000,
      S_DRAIN    = 17'h02000,
      S_DECIDE   = 17'h04000,
      S_RESTORE  = 17'h08000,
      S_FIN      = 17'h10000
   } state_type;

   state_type state_ff, state_in;

   // Configuration
   logic [8:0]         atom_count_ff;
   logic [LenBits-1:0] start_len_ff;
   logic [15:0]        step_ff;
   logic [15:0]        shrink_ff;
   logic               csr_wr;

   // Working state
   opcode_type          op_ff;
   logic [AtomBits-1:0] idx_ff;
   logic [15:0]         drx_ff, dry_ff, drz_ff;
   logic [LenBits-1:0]  box_ff, len_ff;
   logic [15:0]         r_ff;
   logic [TryBits-1:0]  tries_ff;
   logic [1:0]          status_ff;
   logic [AtomBits-1:0] i_ff, j_ff;
   logic                ovl_ff, pend_ff;
   atom_type            ai_ff, save_ff;
   logic [31:0]         magx_ff, magy_ff, magz_ff;
   logic                negx_ff, negy_ff, negz_ff;
   logic [47:0]         prod_ff;

   // Result register
   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff;
   logic [LenBits-1:0]  rsp_box_ff;
   logic [TryBits-1:0]  rsp_tries_ff;

   logic          accept, fin_go;
   logic [8:0]    n_act;
   logic          last_j, last_i;
   logic [23:0]   mul_a, mul_b;
   logic          mul_en;
   logic [32:0]   grow_round, cand_round;
   logic          mem_we;
   logic [AtomBits-1:0] mem_waddr, mem_raddr;
   atom_type      mem_wdata, mem_rdata, moved;
   pair_stat_type pstat;

   function automatic logic [15:0] disp_mag(input logic [15:0] d);
      disp_mag = (d >= HalfQ16) ? d - HalfQ16 : HalfQ16 - d;
   endfunction

   function automatic logic [15:0] apply_disp(input logic [15:0] c, input logic [31:0] mag,
                                              input logic neg);
      logic [32:0] rnd;
      logic [16:0] m;
      logic [16:0] res;
      begin
         rnd = {1'b0, mag} + 33'd32768;
         m   = rnd[32:16];
         res = neg ? {1'b0, c} - m : {1'b0, c} + m;
         apply_disp = res[15:0];
      end
   endfunction

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign fin_go = !rsp_valid_ff || rsp_ready;
   assign n_act = (atom_count_ff > 9'd256) ? 9'd256 : atom_count_ff;
   assign last_j = (j_ff == i_ff - 8'd1);
   assign last_i = ({1'b0, i_ff} == n_act - 9'd1);

   // Configuration port
   assign csr_wr = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      unique case (paddr[3:2])
         REG_ATOM_COUNT: prdata = {23'b0, atom_count_ff};
         REG_START_LEN:  prdata = {8'b0, start_len_ff};
         REG_STEP:       prdata = {16'b0, step_ff};
         REG_SHRINK:     prdata = {16'b0, shrink_ff};
         default:        prdata = 32'b0;
      endcase
   end

   // Shared length multiplier
   always_comb begin
      mul_a  = 24'b0;
      mul_b  = 24'b0;
      mul_en = 1'b1;
      unique case (state_ff)
         S_GROW: begin
            mul_a = len_ff;
            mul_b = {7'b0, GrowQ16};
         end
         S_CAND: begin
            mul_a = box_ff;
            mul_b = {7'b0, OneQ16 - {1'b0, r_ff}};
         end
         S_DECAY: begin
            mul_a = {8'b0, r_ff};
            mul_b = {8'b0, DecayQ16};
         end
         S_SQ: begin
            mul_a = len_ff;
            mul_b = len_ff;
         end
         default: mul_en = 1'b0;
      endcase
   end

   assign grow_round = prod_ff[48-1:16] + 33'd0 + {32'b0, prod_ff[15]};
   assign cand_round = grow_round;

   // Atom store ports
   assign moved.rad = save_ff.rad;
   assign moved.x   = apply_disp(save_ff.x, magx_ff, negx_ff);
   assign moved.y   = apply_disp(save_ff.y, magy_ff, negy_ff);
   assign moved.z   = apply_disp(save_ff.z, magz_ff, negz_ff);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = save_ff;
      if (accept && opcode_type'(req_opcode) == OP_LOAD) begin
         mem_we    = 1'b1;
         mem_waddr = req_atom_index;
         mem_wdata = '{rad: req_radius, z: req_pos_z, y: req_pos_y, x: req_pos_x};
      end else if (state_ff == S_MV_WR) begin
         mem_we    = 1'b1;
         mem_wdata = moved;
      end else if (state_ff == S_RESTORE) begin
         mem_we    = 1'b1;
      end
   end

   always_comb begin
      unique case (state_ff)
         S_IDLE:  mem_raddr = req_atom_index;
         S_CHK_I: mem_raddr = i_ff;
         default: mem_raddr = j_ff;
      endcase
   end

   hsmc_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   hsmc_pair u_pair (
      .clock    (clock),
      .reset    (reset),
      .in_valid (pend_ff),
      .atom_a   (ai_ff),
      .atom_b   (mem_rdata),
      .len_sq   (prod_ff),
      .stat     (pstat)
   );

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (opcode_type'(req_opcode))
                  OP_LOAD:     state_in = S_FIN;
                  OP_EXPAND:   state_in = S_SQ;
                  OP_MOVE:     state_in = ({1'b0, req_atom_index} >= n_act) ? S_FIN
                                                                             : S_MV_DISP;
                  OP_COMPRESS: state_in = S_CAND;
                  default:     state_in = S_FIN;
               endcase
            end
         end
         S_MV_DISP:  state_in = S_MV_WR;
         S_MV_WR:    state_in = S_SQ;
         S_GROW:     state_in = S_GROW_WB;
         S_GROW_WB:  state_in = S_SQ;
         S_CAND:     state_in = S_CAND_WB;
         S_CAND_WB:  state_in = S_SQ;
         S_DECAY:    state_in = S_DECAY_WB;
         S_DECAY_WB: state_in = S_CAND;
         S_SQ:       state_in = (n_act < 9'd2) ? S_DECIDE : S_CHK_I;
         S_CHK_I:    state_in = S_CHK_A;
         S_CHK_A, S_CHK_J: begin
            if (last_j) begin
               state_in = last_i ? S_DRAIN : S_CHK_I;
            end else begin
               state_in = S_CHK_J;
            end
         end
         S_DRAIN:    state_in = (!pend_ff && !pstat.busy) ? S_DECIDE : S_DRAIN;
         S_DECIDE: begin
            if (!ovl_ff) begin
               state_in = S_FIN;
            end else if (op_ff == OP_MOVE) begin
               state_in = S_RESTORE;
            end else if (tries_ff == TryBits'(MaxTries)) begin
               state_in = S_FIN;
            end else begin
               state_in = (op_ff == OP_EXPAND) ? S_GROW : S_DECAY;
            end
         end
         S_RESTORE:  state_in = S_FIN;
         S_FIN:      state_in = fin_go ? S_IDLE : S_FIN;
         default:    state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         atom_count_ff <= 9'd0;
         start_len_ff  <= ResetLength;
         step_ff       <= 16'd3277;
         shrink_ff     <= 16'd6554;
         box_ff        <= ResetLength;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= (state_ff == S_CHK_A) || (state_ff == S_CHK_J);
         if (csr_wr) begin
            unique case (paddr[3:2])
               REG_ATOM_COUNT: atom_count_ff <= pwdata[8:0];
               REG_START_LEN:  start_len_ff  <= pwdata[23:0];
               REG_STEP:       step_ff       <= pwdata[15:0];
               REG_SHRINK:     shrink_ff     <= pwdata[15:0];
               default: ;
            endcase
         end
         if (state_ff == S_DECIDE && !ovl_ff && op_ff != OP_MOVE) begin
            box_ff <= len_ff;
         end else if (state_ff == S_DECIDE && op_ff == OP_EXPAND) begin
            // Expand keeps the last length it checked when it gives up.
            if (tries_ff == TryBits'(MaxTries)) begin
               box_ff <= len_ff;
            end
         end
         if (state_ff == S_FIN && fin_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (pstat.valid && pstat.overlap) begin
         ovl_ff <= 1'b1;
      end
      unique case (state_ff)
         S_IDLE: begin
            op_ff     <= opcode_type'(req_opcode);
            idx_ff    <= req_atom_index;
            drx_ff    <= req_draw_x;
            dry_ff    <= req_draw_y;
            drz_ff    <= req_draw_z;
            len_ff    <= start_len_ff;
            r_ff      <= shrink_ff;
            tries_ff  <= '0;
            status_ff <= (opcode_type'(req_opcode) == OP_MOVE &&
                          {1'b0, req_atom_index} >= n_act) ? ST_REJECT : ST_OK;
         end
         S_MV_DISP: begin
            save_ff <= mem_rdata;
            magx_ff <= disp_mag(drx_ff) * step_ff;
            magy_ff <= disp_mag(dry_ff) * step_ff;
            magz_ff <= disp_mag(drz_ff) * step_ff;
            negx_ff <= drx_ff < HalfQ16;
            negy_ff <= dry_ff < HalfQ16;
            negz_ff <= drz_ff < HalfQ16;
            len_ff  <= box_ff;
         end
         S_GROW_WB: begin
            len_ff <= (grow_round > 33'hFFFFFF) ? 24'hFFFFFF : grow_round[23:0];
         end
         S_CAND_WB:  len_ff <= cand_round[23:0];
         S_DECAY_WB: r_ff <= prod_ff[31:16];
         S_SQ: begin
            // Only expand and compress report how many checks they made.
            if (op_ff != OP_MOVE) begin
               tries_ff <= tries_ff + 1'b1;
            end
            ovl_ff   <= 1'b0;
            i_ff     <= 8'd1;
            j_ff     <= 8'd0;
         end
         S_CHK_A, S_CHK_J: begin
            if (state_ff == S_CHK_A) begin
               ai_ff <= mem_rdata;
            end
            if (last_j) begin
               i_ff <= i_ff + 8'd1;
               j_ff <= 8'd0;
            end else begin
               j_ff <= j_ff + 8'd1;
            end
         end
         S_DECIDE: begin
            if (ovl_ff && op_ff == OP_MOVE) begin
               status_ff <= ST_REJECT;
            end else if (ovl_ff && tries_ff == TryBits'(MaxTries)) begin
               status_ff <= ST_GIVEUP;
            end
         end
         default: ;
      endcase
      if (state_ff == S_FIN && fin_go) begin
         rsp_status_ff <= status_ff;
         rsp_box_ff    <= box_ff;
         rsp_tries_ff  <= tries_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_box_size   = rsp_box_ff;
   assign rsp_tries_used = rsp_tries_ff;

endmodule

### src/hsmc_checker.sv
// Port-level checks for the hard-sphere engine, bound to the top level.
// Depends on hsmc_pkg for status codes and the try limit.
`timescale 1ns / 1ps
module hsmc_checker
   import hsmc_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [1:0]          rsp_status,
   input logic [LenBits-1:0]  rsp_box_size,
   input logic [TryBits-1:0]  rsp_tries_used
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_box_size) && $stable(rsp_status))
      else $error("result word changed while stalled");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_REJECT || rsp_status == ST_GIVEUP)
      else $error("bad status code");

   a_giveup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_GIVEUP |-> rsp_tries_used == TryBits'(MaxTries))
      else $error("give-up reported before the try limit");

   a_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_tries_used <= TryBits'(MaxTries))
      else $error("try count above limit");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new word taken while one is in work");

endmodule

bind hard_sphere_mc_compress hsmc_checker u_hsmc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_box_size   (rsp_box_size),
   .rsp_tries_used (rsp_tries_used)
);

### tb/sv/tb_hard_sphere_mc_compress.sv
// Self-checking testbench for hard_sphere_mc_compress: a directed table of words,
// then random phases, scored against an in-bench engine model or fixed expected results.
// Depends on hsmc_pkg and the hard_sphere_mc_compress RTL.
`timescale 1ns / 1ps
module tb_hard_sphere_mc_compress;
   import hsmc_pkg::*;

   localparam int IdleLimit = 400000;
   localparam int HoldCycles = 300;

   typedef struct packed {
      opcode_type op;
      logic [7:0] idx;
      logic [15:0] px;
      logic [15:0] py;
      logic [15:0] pz;
      logic [23:0] rad;
      logic [15:0] wx;
      logic [15:0] wy;
      logic [15:0] wz;
   } req_word_type;

   typedef struct packed {
      logic [1:0] status;
      logic [23:0] box;
      logic [10:0] tries;
   } rsp_word_type;

   typedef struct packed {
      logic       is_cfg;
      logic [1:0] reg_id;
      logic [31:0] val;
      req_word_type w;
      logic       typed;
      rsp_word_type want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid, req_ready;
   logic [1:0] req_opcode;
   logic [7:0] req_atom_index;
   logic [15:0] req_pos_x, req_pos_y, req_pos_z;
   logic [23:0] req_radius;
   logic [15:0] req_draw_x, req_draw_y, req_draw_z;
   logic rsp_valid, rsp_ready;
   logic [1:0] rsp_status;
   logic [23:0] rsp_box_size;
   logic [10:0] rsp_tries_used;
   logic psel, penable, pwrite, pready;
   logic [3:0] paddr;
   logic [31:0] pwdata, prdata;

   hard_sphere_mc_compress i_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Engine copy: atom store, box and configuration.
   atom_type  atoms [MaxAtoms];
   logic [23:0] box_len;
   logic [8:0]  cfg_count;
   logic [23:0] cfg_start;
   logic [15:0] cfg_step;
   logic [15:0] cfg_shrink;

   rsp_word_type pending [$];
   int errors = 0;
   int words_sent = 0;
   int results_seen = 0;
   int give_ups = 0;
   int rejects = 0;
   int idle_cycles = 0;
   bit hold_req = 0;
   dir_row_type dir_rows [$];

   function automatic logic [16:0] wrap_gap(logic [15:0] a, logic [15:0] b);
      logic [16:0] d;
      d = (a >= b) ? {1'b0, a - b} : {1'b0, b - a};
      if (d >= 17'd32768) d = 17'h10000 - d;
      return d;
   endfunction

   function automatic bit pair_hits(int i, int j, logic [23:0] len);
      logic [16:0] dx, dy, dz;
      logic [127:0] d2, lhs, sum, rhs;
      dx = wrap_gap(atoms[i].x, atoms[j].x);
      dy = wrap_gap(atoms[i].y, atoms[j].y);
      dz = wrap_gap(atoms[i].z, atoms[j].z);
      d2 = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy) + 128'(dz) * 128'(dz);
      lhs = d2 * 128'(len) * 128'(len);
      sum = 128'(atoms[i].rad) + 128'(atoms[j].rad);
      rhs = (sum * sum) << 32;
      return lhs < rhs;
   endfunction

   function automatic bit cell_crowded(logic [23:0] len);
      int n;
      n = (cfg_count > 9'd256) ? 256 : int'(cfg_count);
      for (int i = 1; i < n; i++)
         for (int j = 0; j < i; j++)
            if (pair_hits(i, j, len)) return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic [15:0] shift_coord(logic [15:0] c, logic [15:0] draw);
      logic [47:0] mag;
      bit neg;
      neg = draw < 16'h8000;
      mag = neg ? 48'(17'h8000 - draw) * 48'(cfg_step) : 48'(draw - 16'h8000) * 48'(cfg_step);
      mag = (mag + 48'd32768) >> 16;
      return neg ? c - mag[15:0] : c + mag[15:0];
   endfunction

   // Runs one word through the engine copy and returns the result it produces.
   function automatic rsp_word_type step_engine(req_word_type w);
      rsp_word_type r;
      logic [47:0] len, r_frac;
      atom_type keep;
      int n;
      r = '{ST_OK, 24'd0, 11'd0};
      n = (cfg_count > 9'd256) ? 256 : int'(cfg_count);
      case (w.op)
         OP_LOAD: atoms[w.idx] = '{w.rad, w.pz, w.py, w.px};
         OP_EXPAND: begin
            len = 48'(cfg_start);
            forever begin
               r.tries++;
               if (!cell_crowded(len[23:0])) break;
               if (r.tries >= 11'(MaxTries)) begin
                  r.status = ST_GIVEUP;
                  break;
               end
               len = (len * 48'd68813 + 48'd32768) >> 16;
               if (len > 48'hFFFFFF) len = 48'hFFFFFF;
            end
            box_len = len[23:0];
         end
         OP_MOVE: begin
            if (int'(w.idx) >= n) begin
               r.status = ST_REJECT;
            end else begin
               keep = atoms[w.idx];
               atoms[w.idx].x = shift_coord(keep.x, w.wx);
               atoms[w.idx].y = shift_coord(keep.y, w.wy);
               atoms[w.idx].z = shift_coord(keep.z, w.wz);
               if (cell_crowded(box_len)) begin
                  atoms[w.idx] = keep;
                  r.status = ST_REJECT;
               end
            end
         end
         default: begin
            r_frac = 48'(cfg_shrink);
            forever begin
               len = (48'(box_len) * (48'h10000 - r_frac) + 48'd32768) >> 16;
               r.tries++;
               if (!cell_crowded(len[23:0])) begin
                  box_len = len[23:0];
                  break;
               end
               if (r.tries >= 11'(MaxTries)) begin
                  r.status = ST_GIVEUP;
                  break;
               end
               r_frac = (r_frac * 48'd62259) >> 16;
            end
         end
      endcase
      r.box = box_len;
      return r;
   endfunction

   task automatic drain_results();
      while (pending.size() != 0) @(negedge clock);
   endtask

   // Called at a falling edge with the block idle.
   task automatic csr_write(logic [1:0] reg_id, logic [31:0] val);
      req_valid <= 1'b0;
      drain_results();
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= {reg_id, 2'b00};
      pwdata <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (reg_id)
         REG_ATOM_COUNT: cfg_count = val[8:0];
         REG_START_LEN:  cfg_start = val[23:0];
         REG_STEP:       cfg_step = val[15:0];
         default:        cfg_shrink = val[15:0];
      endcase
   endtask

   task automatic send_word(req_word_type w, bit typed = 0, rsp_word_type want = '0);
      int gap;
      rsp_word_type r;
      gap = ($urandom_range(0, 9) < 5) ? 0 :
            (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_opcode <= w.op;
      req_atom_index <= w.idx;
      req_pos_x <= w.px;
      req_pos_y <= w.py;
      req_pos_z <= w.pz;
      req_radius <= w.rad;
      req_draw_x <= w.wx;
      req_draw_y <= w.wy;
      req_draw_z <= w.wz;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      r = step_engine(w);
      if (typed) r = want;
      pending.push_back(r);
      words_sent++;
      @(negedge clock);
   endtask

   function automatic req_word_type rand_word(opcode_type op, logic [7:0] idx);
      req_word_type w;
      w.op = op;
      w.idx = idx;
      w.px = 16'($urandom);
      w.py = 16'($urandom);
      w.pz = 16'($urandom);
      w.rad = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 24'h00FFFF));
      w.wx = 16'($urandom);
      w.wy = 16'($urandom);
      w.wz = 16'($urandom);
      return w;
   endfunction

   function automatic dir_row_type cfg_row(logic [1:0] reg_id, logic [31:0] val);
      return '{1'b1, reg_id, val, req_word_type'('0), 1'b0, rsp_word_type'('0)};
   endfunction

   function automatic dir_row_type op_row(opcode_type op, logic [7:0] idx, logic [15:0] px,
                                          logic [15:0] py, logic [15:0] pz, logic [23:0] rad,
                                          logic [15:0] wx, logic [15:0] wy, logic [15:0] wz,
                                          bit typed = 0, rsp_word_type want = '0);
      return '{1'b0, 2'd0, 32'd0, '{op, idx, px, py, pz, rad, wx, wy, wz}, typed, want};
   endfunction

   // Result scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending.size() == 0) begin
            $display("%0t: result with none expected: status %0d box %0d tries %0d",
                     $time, rsp_status, rsp_box_size, rsp_tries_used);
            errors++;
         end else begin
            rsp_word_type e;
            e = pending.pop_front();
            if (rsp_status == ST_GIVEUP) give_ups++;
            if (rsp_status == ST_REJECT) rejects++;
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
               errors++;
            end
            if (rsp_box_size !== e.box) begin
               $display("%0t: box_size expected %0d actual %0d", $time, e.box, rsp_box_size);
               errors++;
            end
            if (rsp_tries_used !== e.tries) begin
               $display("%0t: tries_used expected %0d actual %0d",
                        $time, e.tries, rsp_tries_used);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Receiver: random stalls, and one long hold-off when the sender asks for it.
   initial begin
      int run;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
            hold_req = 0;
         end else if ($urandom_range(0, 9) < 7) begin
            rsp_ready <= 1'b1;
            run = $urandom_range(1, 20);
            repeat (run - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b0;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
            repeat (run - 1) @(negedge clock);
         end
      end
   end

   initial begin
      int n;
      req_valid = 1'b0;
      req_opcode = OP_LOAD;
      req_atom_index = '0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_pos_z = '0;
      req_radius = '0;
      req_draw_x = '0;
      req_draw_y = '0;
      req_draw_z = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      box_len = ResetLength;
      cfg_count = '0;
      cfg_start = ResetLength;
      cfg_step = 16'd3277;
      cfg_shrink = 16'd6554;

      // Atoms 0 and 1 sit on top of each other, so both growth and shrinking give up.
      dir_rows.push_back(op_row(OP_EXPAND, 0, 0, 0, 0, 0, 0, 0, 0, 1, '{ST_OK, 24'd81920, 11'd1}));
      dir_rows.push_back(op_row(OP_LOAD, 255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 0, 0, 0,
                                1, '{ST_OK, 24'd81920, 11'd0}));
      dir_rows.push_back(op_row(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(op_row(OP_LOAD, 1, 0, 0, 0, 24'd16384, 0, 0, 0));
      dir_rows.push_back(op_row(OP_MOVE, 0, 0, 0, 0, 0, 16'hFFFF, 0, 0,
                                1, '{ST_REJECT, 24'd81920, 11'd0}));
      dir_rows.push_back(op_row(OP_COMPRESS, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(cfg_row(REG_ATOM_COUNT, 2));
      dir_rows.push_back(op_row(OP_EXPAND, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(op_row(OP_COMPRESS, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(op_row(OP_MOVE, 1, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      dir_rows.push_back(op_row(OP_MOVE, 5, 0, 0, 0, 0, 16'h1234, 16'h8000, 0));
      dir_rows.push_back(cfg_row(REG_STEP, 16'hFFFF));
      dir_rows.push_back(op_row(OP_MOVE, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(op_row(OP_MOVE, 0, 0, 0, 0, 0, 16'h8000, 16'h8000, 16'h8000));
      dir_rows.push_back(cfg_row(REG_STEP, 0));
      dir_rows.push_back(op_row(OP_MOVE, 1, 0, 0, 0, 0, 16'hFFFF, 16'h0000, 16'h5A5A));
      dir_rows.push_back(cfg_row(REG_SHRINK, 16'hFFFF));
      dir_rows.push_back(op_row(OP_COMPRESS, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(cfg_row(REG_SHRINK, 0));
      dir_rows.push_back(op_row(OP_COMPRESS, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(cfg_row(REG_START_LEN, 1));
      dir_rows.push_back(op_row(OP_EXPAND, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(cfg_row(REG_START_LEN, 24'hFFFFFF));
      dir_rows.push_back(op_row(OP_EXPAND, 0, 0, 0, 0, 0, 0, 0, 0));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[k]) begin
         if (dir_rows[k].is_cfg) csr_write(dir_rows[k].reg_id, dir_rows[k].val);
         else send_word(dir_rows[k].w, dir_rows[k].typed, dir_rows[k].want);
      end

      // Random phases: load atoms in use, fit the box, then moves, compresses, loads.
      for (int ph = 0; ph < 8; ph++) begin
         n = $urandom_range(2, 6);
         csr_write(REG_ATOM_COUNT, n);
         csr_write(REG_START_LEN, $urandom_range(16384, 200000));
         csr_write(REG_STEP, $urandom_range(0, 65535));
         csr_write(REG_SHRINK, $urandom_range(0, 65535));
         if (ph == 2) hold_req = 1;
         for (int a = 0; a < n; a++) send_word(rand_word(OP_LOAD, 8'(a)));
         send_word(rand_word(OP_EXPAND, 8'd0));
         if (ph == 4) begin
            req_valid <= 1'b0;
            drain_results();
         end
         repeat ($urandom_range(6, 10)) begin
            case ($urandom_range(0, 9))
               0: send_word(rand_word(OP_LOAD, 8'($urandom_range(n, 255))));
               1: send_word(rand_word(OP_MOVE, 8'($urandom_range(n, 255))));
               2, 3: send_word(rand_word(OP_COMPRESS, 8'($urandom)));
               default: send_word(rand_word(OP_MOVE, 8'($urandom_range(0, n - 1))));
            endcase
         end
      end

      req_valid <= 1'b0;
      drain_results();
      repeat (50) @(negedge clock);
      $display("Covered %0d words and %0d results, %0d give-ups and %0d rejected moves,",
               words_sent, results_seen, give_ups, rejects);
      $display("across reset, extreme and random register settings and long output stalls.");
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
